@@ sv/brf_pkg.sv @@
package brf_pkg;

	localparam int DEPTH_DEF    = 1024;
	localparam int MAX_READ_DEF = 64;
	localparam int BYTE_W       = 8;
	localparam int REQ_W        = 7;
	localparam int IDX_W        = 10;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_FIND  = 2'd3
	} brf_op_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_EMPTY   = 2'd2,
		STAT_NOMATCH = 2'd3
	} brf_stat_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_READ = 2'd1,
		S_FIND = 2'd2
	} brf_state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		logic              byte_valid;
		logic              last;
		brf_stat_t         status;
		logic              match_found;
		logic [IDX_W-1:0]  match_index;
		logic [IDX_W-1:0]  used_count;
		logic [IDX_W-1:0]  free_count;
	} brf_res_t;

endpackage

@@ sv/brf_mem.sv @@
module brf_mem import brf_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] store_q [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read, so a stalled consumer keeps its byte.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/brf_seq.sv @@
module brf_seq import brf_pkg::*; #(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int MAX_READ = MAX_READ_DEF,
	parameter int AW       = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [REQ_W-1:0]  request_count,
	output logic              res_valid,
	input  logic              res_ready,
	output brf_res_t          res,
	output logic              wr_en,
	output logic [AW-1:0]     wr_addr,
	output logic [BYTE_W-1:0] wr_data,
	output logic              rd_en,
	output logic [AW-1:0]     rd_addr,
	input  logic [BYTE_W-1:0] rd_data
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam int            LW   = (AW > REQ_W) ? AW : REQ_W;

	brf_state_t        state_q, state_d;
	logic [AW-1:0]     rp_q, rp_d;
	logic [AW-1:0]     wp_q, wp_d;
	logic [AW-1:0]     fill_q, fill_d;
	logic [AW-1:0]     cnt_q, cnt_d;
	logic [AW-1:0]     scan_q, scan_d;
	logic [AW-1:0]     hit_q, hit_d;
	logic [BYTE_W-1:0] key_q, key_d;

	logic [REQ_W-1:0]  req_sat;
	logic [LW-1:0]     n_l;
	logic [AW-1:0]     n;
	logic              key_hit;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == LAST) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		req_sat = (request_count > REQ_W'(MAX_READ)) ? REQ_W'(MAX_READ) : request_count;
		n_l     = (LW'(req_sat) > LW'(fill_q)) ? LW'(fill_q) : LW'(req_sat);
		n       = AW'(n_l);
	end

	// The one byte comparator, shared by every step of a search.
	assign key_hit = (rd_data == key_q);

	assign wr_addr = wp_q;
	assign wr_data = data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rp_q    <= '0;
			wp_q    <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q  <= cnt_d;
		scan_q <= scan_d;
		hit_q  <= hit_d;
		key_q  <= key_d;
	end

	always_comb begin
		state_d   = state_q;
		rp_d      = rp_q;
		wp_d      = wp_q;
		fill_d    = fill_q;
		cnt_d     = cnt_q;
		scan_d    = scan_q;
		hit_d     = hit_q;
		key_d     = key_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = rp_q;

		unique case (state_q)
			S_IDLE: begin
				in_ready = res_ready;
				if (in_valid && res_ready) begin
					unique case (brf_op_t'(opcode))
						OP_WRITE: begin
							res_valid = 1'b1;
							res.last  = 1'b1;
							if (fill_q == LAST) begin
								res.status = STAT_FULL;
							end else begin
								wr_en  = 1'b1;
								wp_d   = ring_next(wp_q);
								fill_d = fill_q + 1'b1;
							end
						end
						OP_READ: begin
							if (n == '0) begin
								res_valid  = 1'b1;
								res.last   = 1'b1;
								res.status = STAT_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rp_d    = ring_next(rp_q);
								fill_d  = fill_q - n;
								cnt_d   = n - 1'b1;
								state_d = S_READ;
							end
						end
						OP_CLEAR: begin
							res_valid = 1'b1;
							res.last  = 1'b1;
							rp_d      = '0;
							wp_d      = '0;
							fill_d    = '0;
						end
						OP_FIND: begin
							if (fill_q == '0) begin
								res_valid  = 1'b1;
								res.last   = 1'b1;
								res.status = STAT_NOMATCH;
							end else begin
								rd_en   = 1'b1;
								hit_d   = rp_q;
								scan_d  = ring_next(rp_q);
								cnt_d   = fill_q - 1'b1;
								key_d   = data_byte;
								state_d = S_FIND;
							end
						end
						default: ;
					endcase
				end
			end
			S_READ: begin
				if (res_ready) begin
					res_valid      = 1'b1;
					res.read_byte  = rd_data;
					res.byte_valid = 1'b1;
					res.last       = (cnt_q == '0);
					if (cnt_q == '0) begin
						state_d = S_IDLE;
					end else begin
						rd_en = 1'b1;
						rp_d  = ring_next(rp_q);
						cnt_d = cnt_q - 1'b1;
					end
				end
			end
			S_FIND: begin
				if (key_hit) begin
					if (res_ready) begin
						res_valid       = 1'b1;
						res.last        = 1'b1;
						res.match_found = 1'b1;
						res.match_index = IDX_W'(hit_q);
						state_d         = S_IDLE;
					end
				end else if (cnt_q == '0) begin
					if (res_ready) begin
						res_valid  = 1'b1;
						res.last   = 1'b1;
						res.status = STAT_NOMATCH;
						state_d    = S_IDLE;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = scan_q;
					hit_d   = scan_q;
					scan_d  = ring_next(scan_q);
					cnt_d   = cnt_q - 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		res.used_count = IDX_W'(fill_d);
		res.free_count = IDX_W'(LAST - fill_d);
	end

	logic [AW-1:0] ptr_span;
	assign ptr_span = (wp_q >= rp_q) ? (wp_q - rp_q) : AW'(DEPTH - int'(rp_q) + int'(wp_q));

	a_span_matches_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (ptr_span == fill_q))
		else $error("pointer distance disagrees with fill level");

	a_find_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |=> ($stable(rp_q) && $stable(wp_q) && $stable(fill_q)))
		else $error("search changed the FIFO state");

	a_write_counts_up: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && opcode == OP_WRITE && fill_q != LAST)
		|=> (fill_q == $past(fill_q) + 1'b1))
		else $error("accepted write did not raise the fill level");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_ready)
		else $error("result pushed into a full output buffer");

endmodule

@@ sv/byte_ring_fifo_with_search.sv @@
// Circular byte FIFO with search, holding up to DEPTH-1 bytes.
//
// Input channel s_*: each item is one operation, selected by s_tuser
// (write, read, clear, find). s_tdata carries the byte to write or to look
// for and the number of bytes a read asks for.
// Output channel m_*: every item accepted yields one or more result items;
// m_tlast marks the final one. Each result carries the used and free counts
// as they stand after the whole operation.
//
// Timing: write, clear, an empty read and a find on an empty FIFO are done
// in the idle state; the result is registered in the output buffer before
// it shows on m_tvalid. A read or a find walks the store one byte per cycle,
// as the store has one read port; a read step waits while the buffer is full.
// s_tready is low while a read or a find is walking the store.
//
// A two-entry output buffer sits between the sequencer and m_*, so one more
// item is taken while a result waits; when m_tready stays low the buffer
// fills and s_tready drops. Read and find steps wait in place, nothing is
// lost. Reset clears the pointers, the fill level and the output buffer;
// the byte store itself has no clearing pass and needs none.
module byte_ring_fifo_with_search import brf_pkg::*; #(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int MAX_READ = MAX_READ_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // data_byte [7:0], request_count [14:8], zero [15]
	input  logic [1:0]  s_tuser,   // opcode [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // read_byte [7:0], match_index [17:8],
	                               // used_count [27:18], free_count [37:28], zero [39:38]
	output logic        m_tlast,
	output logic [3:0]  m_tuser    // byte_valid [0], status [2:1], match_found [3]
);

	localparam int AW = $clog2(DEPTH);

	// Memory port between the sequencer and the store.
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [BYTE_W-1:0] rd_data;

	// Result push from the sequencer into the output buffer.
	logic     res_valid;
	logic     res_ready;
	brf_res_t res;

	brf_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	brf_seq #(
		.DEPTH    (DEPTH),
		.MAX_READ (MAX_READ),
		.AW       (AW)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.opcode        (s_tuser),
		.data_byte     (s_tdata[7:0]),
		.request_count (s_tdata[14:8]),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data)
	);

	// Two-entry output buffer: out_q drives the port, skid_q catches a result
	// that arrives while out_q is stalled.
	brf_res_t out_q, skid_q;
	logic     out_v_q, skid_v_q;
	logic     pop;

	assign pop       = out_v_q && m_tready;
	assign res_ready = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= res_valid;
				end else begin
					out_v_q <= res_valid;
				end
			end else if (res_valid) begin
				if (!out_v_q) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (res_valid) begin
					skid_q <= res;
				end
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			if (!out_v_q) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {2'b00, out_q.free_count, out_q.used_count,
	                   out_q.match_index, out_q.read_byte};
	assign m_tuser  = {out_q.match_found, out_q.status, out_q.byte_valid};

endmodule
